// File: hdl/tfr_pkg.sv
// Shared types, codes and helpers for the typed frame receiver.
`default_nettype none

package tfr_pkg;

  // Widths fixed by the channel fields
  localparam int BYTE_W    = 8;
  localparam int EVENT_W   = 3;
  localparam int TYPE_W    = 4;
  localparam int IDX_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Default payload buffer depth
  localparam int BUFFER_DEPTH_DEF = 64;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_TYPE = 3'd2,
    PH_AT   = 3'd3,
    PH_BODY = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  // Result event codes
  typedef enum logic [EVENT_W-1:0] {
    EV_IGNORED  = 3'd0,
    EV_OPENED   = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_COMPLETE = 3'd3,
    EV_DISCARD  = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_AT    = 2'd2
  } reg_idx_t;

  // Frame type codes
  localparam logic [TYPE_W-1:0] TYPE_NONE   = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_L      = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_T      = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_W_CODE = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_A      = 4'd4;
  localparam logic [TYPE_W-1:0] TYPE_S      = 4'd5;
  localparam logic [TYPE_W-1:0] TYPE_M      = 4'd6;
  localparam logic [TYPE_W-1:0] TYPE_G      = 4'd7;
  localparam logic [TYPE_W-1:0] TYPE_AT_CMD = 4'd8;

  // Character constants
  localparam logic [BYTE_W-1:0] CHR_L  = 8'h4C;
  localparam logic [BYTE_W-1:0] CHR_T  = 8'h54;
  localparam logic [BYTE_W-1:0] CHR_W  = 8'h57;
  localparam logic [BYTE_W-1:0] CHR_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_S  = 8'h53;
  localparam logic [BYTE_W-1:0] CHR_M  = 8'h4D;
  localparam logic [BYTE_W-1:0] CHR_G  = 8'h47;
  localparam logic [BYTE_W-1:0] CHR_NL = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_NUL = 8'h00;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd91;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd93;
  localparam logic [BYTE_W-1:0] AT_BYTE_RST    = 8'd43;

  // Configuration register set
  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] at_byte;
  } cfg_t;

  // Parser control state (count travels separately, its width follows the depth)
  typedef struct packed {
    phase_t            phase;
    logic [TYPE_W-1:0] ftype;
  } ctl_t;

  // One result beat
  typedef struct packed {
    event_t            event_res;
    logic [TYPE_W-1:0] frame_type;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [IDX_W-1:0]  frame_length;
  } res_t;

  // Type letter to frame type code
  function automatic logic [TYPE_W-1:0] letter_code(input logic [BYTE_W-1:0] b);
    logic [TYPE_W-1:0] code;
    case (b)
      CHR_L:   code = TYPE_L;
      CHR_T:   code = TYPE_T;
      CHR_W:   code = TYPE_W_CODE;
      CHR_A:   code = TYPE_A;
      CHR_S:   code = TYPE_S;
      CHR_M:   code = TYPE_M;
      CHR_G:   code = TYPE_G;
      default: code = TYPE_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hdl/tfr_ifs.sv
// Valid/ready channel interfaces for the input, result and configuration ports.
`default_nettype none

// Received byte channel
interface tfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [tfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface tfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tfr_pkg::EVENT_W-1:0] event_res;
  logic [tfr_pkg::TYPE_W-1:0]  frame_type;
  logic [tfr_pkg::BYTE_W-1:0]  payload_byte;
  logic [tfr_pkg::IDX_W-1:0]   byte_index;
  logic [tfr_pkg::IDX_W-1:0]   frame_length;

  modport source (output valid, output event_res, output frame_type, output payload_byte,
                  output byte_index, output frame_length, input ready);
  modport sink   (input valid, input event_res, input frame_type, input payload_byte,
                  input byte_index, input frame_length, output ready);
endinterface

// Configuration write channel
interface tfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tfr_pkg::CFG_IDX_W-1:0] idx;
  logic [tfr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/typed_frame_receiver_with_at_mode.sv
// Top level of the typed frame receiver with AT command mode.
//
//   channel   dir  payload                                          beat when
//   in_chan   in   rx_byte[7:0]                                      valid & ready
//   out_chan  out  event_res, frame_type, payload_byte, byte_index,  valid & ready
//                  frame_length
//   cfg_chan  in   idx[1:0], data[7:0]                               valid & ready
//
// One byte per cycle while the result side keeps taking beats; a byte's result passes
// through the input register, then through the parser step into the result register.
// The parser state updates as a byte moves from the input register to the result register.
// A stalled result holds the input register; ready drops only when both stages are full.
// Synchronous active-low reset clears the parser to the finished phase, type none,
// count zero, and restores the register defaults.
`default_nettype none

module typed_frame_receiver_with_at_mode #(
  parameter int BUFFER_DEPTH = tfr_pkg::BUFFER_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  tfr_in_if.sink   in_chan,
  tfr_out_if.source out_chan,
  tfr_cfg_if.sink  cfg_chan
);
  import tfr_pkg::*;

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  cfg_t              cfg;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  res_t              res_r;
  res_t              res_nxt;
  ctl_t              ctl_r;
  ctl_t              ctl_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              s1_adv;
  logic              in_ready;

  // Configuration registers
  tfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // Parser step
  tfr_decode #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CNT_W        (CNT_W)
  ) u_decode (
    .rx_byte   (s1_byte_r),
    .cfg       (cfg),
    .ctl       (ctl_r),
    .count     (count_r),
    .ctl_nxt   (ctl_nxt),
    .count_nxt (count_nxt),
    .res       (res_nxt)
  );

  // Stage handshake
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready      = !s1_valid_r || s1_adv;
  assign in_chan.ready = in_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r.phase <= PH_DONE;
      ctl_r.ftype <= TYPE_NONE;
      count_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        ctl_r       <= ctl_nxt;
        count_r     <= count_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) begin
      s1_byte_r <= in_chan.rx_byte;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  // Result port
  assign out_chan.valid        = out_valid_r;
  assign out_chan.event_res    = res_r.event_res;
  assign out_chan.frame_type   = res_r.frame_type;
  assign out_chan.payload_byte = res_r.payload_byte;
  assign out_chan.byte_index   = res_r.byte_index;
  assign out_chan.frame_length = res_r.frame_length;

`ifndef NO_ASSERTIONS
  // Count never passes the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(BUFFER_DEPTH))
    else $error("byte count beyond buffer depth");

  // Waiting for a type letter only ever happens with the type cleared
  a_type_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.phase == PH_TYPE |-> ctl_r.ftype == TYPE_NONE)
    else $error("type letter expected with a type already set");

  // AT mode sits only in the AT or wait phase
  a_at_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.ftype == TYPE_AT_CMD |-> (ctl_r.phase == PH_AT || ctl_r.phase == PH_WAIT))
    else $error("AT type outside AT phases");

  // Parser state holds while the result stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> $stable(count_r) && $stable(ctl_r))
    else $error("parser state moved during result stall");
`endif

endmodule

`default_nettype wire

// File: hdl/tfr_cfg_regs.sv
// Configuration register file: start, end and AT byte values.
`default_nettype none

module tfr_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst_n,
  tfr_cfg_if.sink      cfg_chan,
  output tfr_pkg::cfg_t cfg
);
  import tfr_pkg::*;

  cfg_t cfg_r;

  // Writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  // Register write decode; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= START_BYTE_RST;
      cfg_r.end_byte   <= END_BYTE_RST;
      cfg_r.at_byte    <= AT_BYTE_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.idx)
        REG_START: cfg_r.start_byte <= cfg_chan.data;
        REG_END:   cfg_r.end_byte   <= cfg_chan.data;
        REG_AT:    cfg_r.at_byte    <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/tfr_decode.sv
// Single-byte parser step: next parser state and the result beat for one byte.
`default_nettype none

module tfr_decode #(
  parameter int BUFFER_DEPTH = tfr_pkg::BUFFER_DEPTH_DEF,
  parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1)
) (
  input  wire logic [tfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire tfr_pkg::cfg_t              cfg,
  input  wire tfr_pkg::ctl_t              ctl,
  input  wire logic [CNT_W-1:0]           count,
  output tfr_pkg::ctl_t                   ctl_nxt,
  output logic [CNT_W-1:0]                count_nxt,
  output tfr_pkg::res_t                   res
);
  import tfr_pkg::*;

  logic is_start, is_at, is_end, is_nl, is_nul, in_type, at_mode, full;
  logic [CNT_W-1:0] at_len;
  phase_t            phase_nxt;
  logic [TYPE_W-1:0] ftype_nxt;

  // Byte classification, in priority order below
  assign is_start = (rx_byte == cfg.start_byte);
  assign is_at    = (rx_byte == cfg.at_byte);
  assign is_end   = (rx_byte == cfg.end_byte);
  assign is_nl    = (rx_byte == CHR_NL);
  assign is_nul   = (rx_byte == CHR_NUL);
  assign in_type  = (ctl.phase == PH_TYPE);
  assign at_mode  = (ctl.ftype == TYPE_AT_CMD);
  assign full     = (count == CNT_W'(BUFFER_DEPTH));
  // AT length: count minus one, floor at zero
  assign at_len   = (count == '0) ? '0 : count - CNT_W'(1);

  assign ctl_nxt = '{phase: phase_nxt, ftype: ftype_nxt};

  // Next phase
  always_comb begin
    phase_nxt = ctl.phase;
    if (is_start) begin
      phase_nxt = PH_TYPE;
    end else if (is_at) begin
      phase_nxt = PH_AT;
    end else if (in_type) begin
      phase_nxt = PH_BODY;
    end else if (at_mode) begin
      if (!is_nul && is_nl) begin
        phase_nxt = PH_WAIT;
      end
    end else if (is_end) begin
      phase_nxt = PH_WAIT;
    end else if (ctl.phase != PH_BODY) begin
      phase_nxt = PH_IDLE;
    end
  end

  // Type, count and result beat
  always_comb begin
    ftype_nxt        = ctl.ftype;
    count_nxt        = count;
    res.event_res    = EV_IGNORED;
    res.payload_byte = '0;
    res.byte_index   = '0;
    res.frame_length = '0;
    if (is_start) begin
      ftype_nxt     = TYPE_NONE;
      count_nxt     = '0;
      res.event_res = EV_OPENED;
    end else if (is_at) begin
      ftype_nxt     = TYPE_AT_CMD;
      count_nxt     = '0;
      res.event_res = EV_OPENED;
    end else if (in_type) begin
      ftype_nxt     = letter_code(rx_byte);
      res.event_res = EV_OPENED;
    end else if (at_mode && is_nul) begin
      res.event_res = EV_IGNORED;
    end else if (at_mode && is_nl) begin
      res.frame_length = IDX_W'(at_len);
      count_nxt        = '0;
      res.event_res    = EV_COMPLETE;
    end else if (!at_mode && is_end) begin
      res.frame_length = IDX_W'(count);
      count_nxt        = '0;
      res.event_res    = EV_COMPLETE;
    end else if (!at_mode && ctl.phase != PH_BODY) begin
      res.event_res = EV_DISCARD;
    end else if (full) begin
      res.event_res = EV_OVERFLOW;
    end else begin
      // Payload byte, AT or typed body
      res.payload_byte = rx_byte;
      res.byte_index   = IDX_W'(count);
      count_nxt        = count + CNT_W'(1);
      res.event_res    = EV_PAYLOAD;
    end
    res.frame_type = ftype_nxt;
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the typed frame receiver with AT command mode.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tfr_pkg::*;

  localparam int          BUFFER_DEPTH = BUFFER_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 200;
  // index 3 is not a register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  tfr_in_if  in_if ();
  tfr_out_if out_if ();
  tfr_cfg_if cfg_if ();

  typed_frame_receiver_with_at_mode u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #10 clk = ~clk;

  // Predictor state and register copies
  logic [BYTE_W-1:0] start_val, end_val, at_val;
  phase_t            rx_phase;
  logic [TYPE_W-1:0] rx_type;
  logic [IDX_W-1:0]  rx_fill;

  res_t        pending_events[$];
  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned in_idle_pct  = 33;
  int unsigned out_idle_pct = 33;
  int unsigned hold_left    = 0;

  logic [BYTE_W-1:0] type_letters[7] = '{CHR_L, CHR_T, CHR_W, CHR_A, CHR_S, CHR_M, CHR_G};

  function automatic logic [TYPE_W-1:0] type_of_letter(input logic [BYTE_W-1:0] b);
    case (b)
      CHR_L:   return TYPE_L;
      CHR_T:   return TYPE_T;
      CHR_W:   return TYPE_W_CODE;
      CHR_A:   return TYPE_A;
      CHR_S:   return TYPE_S;
      CHR_M:   return TYPE_M;
      CHR_G:   return TYPE_G;
      default: return TYPE_NONE;
    endcase
  endfunction

  // One byte through the parser: updates the predicted state, returns the event beat
  function automatic res_t parse_step(input logic [BYTE_W-1:0] b);
    res_t r;
    logic collect;
    r = '0;
    r.event_res = EV_IGNORED;
    collect = 1'b0;
    if (b == start_val) begin
      // start byte wins over every other match
      rx_type = TYPE_NONE;
      rx_fill = '0;
      rx_phase = PH_TYPE;
      r.event_res = EV_OPENED;
    end else if (b == at_val) begin
      rx_type = TYPE_AT_CMD;
      rx_fill = '0;
      rx_phase = PH_AT;
      r.event_res = EV_OPENED;
    end else if (rx_phase == PH_TYPE) begin
      rx_type = type_of_letter(b);
      rx_phase = PH_BODY;
      r.event_res = EV_OPENED;
    end else if (rx_type == TYPE_AT_CMD) begin
      if (b == CHR_NUL) begin
        r.event_res = EV_IGNORED;
      end else if (b == CHR_NL) begin
        // count plus newline, minus two, floored at zero
        r.frame_length = (rx_fill != '0) ? rx_fill - 1'b1 : '0;
        rx_fill = '0;
        rx_phase = PH_WAIT;
        r.event_res = EV_COMPLETE;
      end else begin
        collect = 1'b1;
      end
    end else if (b == end_val) begin
      r.frame_length = rx_fill;
      rx_fill = '0;
      rx_phase = PH_WAIT;
      r.event_res = EV_COMPLETE;
    end else if (rx_phase != PH_BODY) begin
      rx_phase = PH_IDLE;
      r.event_res = EV_DISCARD;
    end else begin
      collect = 1'b1;
    end
    // payload store, or overflow once the buffer is full
    if (collect) begin
      if (rx_fill >= BUFFER_DEPTH) begin
        r.event_res = EV_OVERFLOW;
      end else begin
        r.payload_byte = b;
        r.byte_index = rx_fill;
        rx_fill = rx_fill + 1'b1;
        r.event_res = EV_PAYLOAD;
      end
    end
    r.frame_type = rx_type;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Result checker: compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: result beat with no expected event, actual event %0d",
                 $time, out_if.event_res);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", want.event_res, out_if.event_res);
        check_field("frame_type", want.frame_type, out_if.frame_type);
        check_field("payload_byte", want.payload_byte, out_if.payload_byte);
        check_field("byte_index", want.byte_index, out_if.byte_index);
        check_field("frame_length", want.frame_length, out_if.frame_length);
      end
    end
  end

  // Result side ready: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d events still expected", $time, pending_events.size());
      $display("typed_frame_receiver_with_at_mode regression: fail");
      $finish;
    end
  end

  // Offer one byte, with random gaps; valid stays high after the beat
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_events.push_back(parse_step(b));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_START: start_val = val;
      REG_END:   end_val = val;
      REG_AT:    at_val = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                          input logic [BYTE_W-1:0] a);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_AT, a);
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic send_random_frame();
    int unsigned kind, len;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(99);
    len = ($urandom_range(19) == 0) ? $urandom_range(BUFFER_DEPTH + 4, BUFFER_DEPTH - 2)
                                    : $urandom_range(8);
    if (kind < 50) begin
      send_byte(start_val);
      if ($urandom_range(99) < 85)
        send_byte(type_letters[3'($urandom_range(6))]);
      else
        send_byte(BYTE_W'($urandom_range(255)));
      repeat (len) send_byte(BYTE_W'($urandom_range(255)));
      if ($urandom_range(9) != 0) send_byte(end_val);
    end else if (kind < 80) begin
      send_byte(at_val);
      repeat (len) begin
        b = ($urandom_range(99) < 15) ? CHR_NUL : BYTE_W'($urandom_range(255));
        send_byte(b);
      end
      if ($urandom_range(9) != 0) send_byte(CHR_NL);
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned stop;
    stop = items_sent + n;
    while (items_sent < stop) send_random_frame();
  endtask

  // Every type letter, byte extremes, stray and end bytes outside a frame, AT basics
  task automatic test_directed_frames();
    int unsigned k;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(end_val);
    send_byte(start_val);
    send_byte(CHR_L);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(end_val);
    for (k = 1; k < 7; k++) begin
      send_byte(start_val);
      send_byte(type_letters[3'(k)]);
    end
    // unknown letter gives type none, then an empty frame
    send_byte(start_val);
    send_byte(8'h78);
    send_byte(end_val);
    // AT: zero dropped, end byte collected, newline gives the count minus one
    send_byte(at_val);
    send_byte(CHR_NUL);
    send_byte(CHR_A);
    send_byte(end_val);
    send_byte(CHR_NL);
    send_byte(CHR_NL);
    send_byte(start_val);
  endtask

  // Fill past the buffer in both modes
  task automatic test_buffer_overflow();
    int unsigned k;
    send_byte(start_val);
    send_byte(CHR_S);
    for (k = 0; k < BUFFER_DEPTH + 2; k++) send_byte(8'h60 + BYTE_W'(k % 16));
    send_byte(end_val);
    send_byte(at_val);
    for (k = 0; k < BUFFER_DEPTH + 2; k++) send_byte(8'h60 + BYTE_W'(k % 16));
    send_byte(CHR_NL);
  endtask

  // Long result hold-off while bytes keep coming, so the input stalls
  task automatic test_result_stall();
    wait_drained();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    test_random_traffic(40);
  endtask

  // Register extremes, the AT byte equal to the start byte, a spare index write
  task automatic test_register_extremes();
    set_regs(8'h00, 8'hFF, 8'h01);
    write_reg(REG_SPARE, 8'hA5);
    send_byte(8'h00);
    send_byte(CHR_M);
    send_byte(START_BYTE_RST);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CHR_NL);
    test_random_traffic(70);

    set_regs(8'hFF, 8'h00, 8'hFF);
    send_byte(8'hFF);
    send_byte(CHR_G);
    send_byte(8'h00);
    // a stretch with no gaps on either side
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_traffic(70);
    in_idle_pct = 33;
    out_idle_pct = 33;

    set_regs(START_BYTE_RST, END_BYTE_RST, AT_BYTE_RST);
    test_random_traffic(70);
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.idx = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    start_val = START_BYTE_RST;
    end_val = END_BYTE_RST;
    at_val = AT_BYTE_RST;
    rx_phase = PH_DONE;
    rx_type = TYPE_NONE;
    rx_fill = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_buffer_overflow();
    test_random_traffic(50);
    test_result_stall();
    test_register_extremes();

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("typed_frame_receiver_with_at_mode regression: pass");
    else
      $display("typed_frame_receiver_with_at_mode regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hdl/tfr_pkg.sv
hdl/tfr_ifs.sv
hdl/tfr_cfg_regs.sv
hdl/tfr_decode.sv
hdl/typed_frame_receiver_with_at_mode.sv
dv/tb_top.sv
